/* src/s256h_pkg.sv */
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// sequencer states, round-unit control and the SHA-256 mixing functions.
// No dependencies.
`default_nettype none

package s256h_pkg;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned ROUNDS       = 64;
  localparam int unsigned DIGEST_WORDS = 8;

  localparam logic [5:0] LAST_BYTE_POS = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_FILL      = 6'd56;
  localparam logic [5:0] LAST_ROUND    = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD_POS = 3'(DIGEST_WORDS - 1);
  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [63:0] BYTE_BITS    = 64'd8;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic init_hash;
    logic load_work;
    logic round_en;
    logic fold;
    logic rotate;
  } rnd_ctrl_t;

  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

/* src/s256h_sched.sv */
// Block buffer and message schedule: a 512-bit shift line that takes bytes
// and, during the rounds, produces one schedule word per cycle.
// Depends on s256h_pkg.
`default_nettype none

module s256h_sched
  import s256h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] shift_byte,
  input  wire logic       round_en,
  output word_t           w_top
);

  logic [511:0] window;
  word_t        w_new;

  assign w_top = window[511:480];

  always_comb begin
    w_new = small_sigma1(window[63:32]) + window[223:192]
          + small_sigma0(window[479:448]) + window[511:480];
  end

  always_ff @(posedge clk) begin
    if (round_en) begin
      window <= {window[479:0], w_new};
    end else if (shift_en) begin
      window <= {window[503:0], shift_byte};
    end
  end

endmodule

`default_nettype wire

/* src/s256h_round.sv */
// Shared SHA-256 round unit with the working variables and the hash state;
// also folds the block result into the hash and rotates it out as digest.
// Depends on s256h_pkg.
`default_nettype none

module s256h_round
  import s256h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rnd_ctrl_t  ctrl,
  input  wire logic [5:0] round_idx,
  input  wire word_t      w_in,
  output word_t           hash_top
);

  word_t hash [DIGEST_WORDS];
  word_t work [DIGEST_WORDS];
  word_t t1;
  word_t t2;

  assign hash_top = hash[0];

  always_comb begin
    t1 = work[7] + big_sigma1(work[4])
       + ((work[4] & work[5]) ^ (~work[4] & work[6]))
       + ROUND_K[round_idx] + w_in;
    t2 = big_sigma0(work[0])
       + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init_hash) begin
      hash <= INIT_H;
    end else if (ctrl.fold) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        hash[i] <= hash[i] + work[i];
      end
    end else if (ctrl.rotate) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        hash[i] <= hash[i + 1];
      end
      hash[DIGEST_WORDS - 1] <= hash[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_work) begin
      work <= hash;
    end else if (ctrl.round_en) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

endmodule

`default_nettype wire

/* src/sha256_stream_hasher_unit.sv */
// SHA-256 stream hasher top level: byte intake, padding and length sequencer,
// digest output. Depends on s256h_pkg, s256h_sched and s256h_round.
//
// Usage: the input channel (in_valid, in_stall) carries one request per
// message byte; byte_present marks a real byte and is_last ends the message.
// When a byte fills a 64-byte block, the block is compressed (one load,
// 64 rounds, one fold) while in_stall is high; the single round unit does
// one round per cycle.
// A request with is_last starts padding: the 0x80 byte, zeros and the
// 8-byte bit length are fed through the buffer at one byte per cycle, with
// one or two further compressions before the digest appears.
// The output channel (out_valid, out_stall) then carries eight requests,
// word 0 first, last_word on word 7. A stall holds the current word; no
// input is taken until the eighth word is accepted, after which the hash
// state returns to its initial values.
// Reset (rst, synchronous) restarts the hasher with an empty message.
`default_nettype none

module sha256_stream_hasher_unit
  import s256h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [5:0]  round_cnt;
  logic [2:0]  emit_cnt;
  logic        finishing;
  logic        sent80;
  logic        len_block;

  logic        in_accept;
  logic        out_accept;
  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        len_now;
  rnd_ctrl_t   ctrl;
  word_t       w_top;
  word_t       hash_top;

  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign out_valid   = (state == ST_EMIT);
  assign out_accept  = out_valid && !out_stall;
  assign digest_word = hash_top;
  assign word_index  = emit_cnt;
  assign last_word   = (emit_cnt == LAST_WORD_POS);
  assign len_now     = sent80 && (len_block || fill == LEN_FILL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    shift_en   = 1'b0;
    shift_byte = msg_byte;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          shift_en = byte_present;
          if (byte_present && fill == LAST_BYTE_POS) begin
            state_next = ST_LOAD;
          end else if (is_last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
        if (!sent80) begin
          shift_byte = PAD_BYTE;
        end else if (len_now) begin
          shift_byte = msg_bits[63:56];
        end else begin
          shift_byte = ZERO_BYTE;
        end
        if (fill == LAST_BYTE_POS) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl.load_work = 1'b1;
        state_next     = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.round_en = 1'b1;
        if (round_cnt == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (finishing && len_block) begin
          state_next = ST_EMIT;
        end else if (finishing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (emit_cnt == LAST_WORD_POS) begin
            ctrl.init_hash = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            ctrl.rotate = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      msg_bits  <= '0;
      round_cnt <= '0;
      emit_cnt  <= '0;
      finishing <= 1'b0;
      sent80    <= 1'b0;
      len_block <= 1'b0;
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
      end
      if (in_accept && byte_present) begin
        msg_bits <= msg_bits + BYTE_BITS;
      end else if (state == ST_PAD && len_now) begin
        msg_bits <= {msg_bits[55:0], ZERO_BYTE};
      end
      if (ctrl.round_en) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (out_accept) begin
        emit_cnt <= emit_cnt + 3'd1;
      end
      if (in_accept && is_last) begin
        finishing <= 1'b1;
      end else if (out_accept && last_word) begin
        finishing <= 1'b0;
      end
      if (state == ST_PAD) begin
        sent80 <= 1'b1;
      end else if (out_accept && last_word) begin
        sent80 <= 1'b0;
      end
      if (state == ST_PAD && len_now) begin
        len_block <= 1'b1;
      end else if (out_accept && last_word) begin
        len_block <= 1'b0;
      end
    end
  end

  s256h_sched u_sched (
    .clk        (clk),
    .shift_en   (shift_en),
    .shift_byte (shift_byte),
    .round_en   (ctrl.round_en),
    .w_top      (w_top)
  );

  s256h_round u_round (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .round_idx (round_cnt),
    .w_in      (w_top),
    .hash_top  (hash_top)
  );

  // The length bytes have been shifted out completely by the time the digest is shown.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (msg_bits == '0 && fill == '0 && finishing && len_block))
    else $error("digest shown before padding completed");

  // A compression always starts from round zero.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |=> (state == ST_ROUND && round_cnt == '0))
    else $error("round counter not aligned at block start");

  // After the eighth word the hasher is back at its initial state.
  assert property (@(posedge clk) disable iff (rst)
    out_accept && last_word |=> (state == ST_IDLE && !finishing && !sent80 && emit_cnt == '0))
    else $error("hasher not reinitialized after digest");

  // The padding byte goes out before any length byte.
  assert property (@(posedge clk) disable iff (rst)
    len_block |-> sent80)
    else $error("length bytes sent before the padding byte");

endmodule

`default_nettype wire

/* tb/sha256_stream_hasher_unit_checker.sv */
// Scoreboard for the SHA-256 stream hasher: it watches both channels, runs its own
// SHA-256 over every accepted request and compares each digest word as it leaves.
// Depends only on the port list of sha256_stream_hasher_unit.
module sha256_stream_hasher_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  digest_entry_t want_q [$];
  bit [31:0]     chain_words [8];
  bit [7:0]      block_bytes [64];
  int unsigned   block_fill;
  bit [63:0]     bits_done;
  int            mismatches;

  function automatic bit [31:0] rotr(input bit [31:0] x, input int unsigned n);
    bit [63:0] both;
    both = {x, x} >> n;
    return both[31:0];
  endfunction

  function automatic void restart_hash();
    chain_words = H_START;
    block_bytes = '{default: 8'h00};
    block_fill  = 0;
    bits_done   = 64'd0;
  endfunction

  function automatic void compress_block();
    bit [31:0] w [64];
    bit [31:0] v [8];
    bit [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = chain_words;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      chain_words[i] = chain_words[i] + v[i];
    end
  endfunction

  function automatic void absorb_request(input bit [7:0] b, input bit present, input bit ends);
    bit [63:0]   total;
    int unsigned pos;
    if (present) begin
      block_bytes[block_fill] = b;
      block_fill++;
      if (block_fill == 64) begin
        compress_block();
        bits_done  += 64'd512;
        block_fill = 0;
      end
    end
    if (!ends) return;
    pos   = block_fill;
    total = bits_done + 64'(pos) * 64'd8;
    block_bytes[pos] = 8'h80;
    for (int j = pos + 1; j < 64; j++) block_bytes[j] = 8'h00;
    if (pos >= 56) begin
      compress_block();
      block_bytes = '{default: 8'h00};
    end
    for (int j = 0; j < 8; j++) block_bytes[63-j] = total[8*j +: 8];
    compress_block();
    for (int j = 0; j < 8; j++) begin
      want_q.push_back('{chain_words[j], 3'(j), j == 7});
    end
    restart_hash();
  endfunction

  always @(posedge clk) begin
    digest_entry_t got, want;
    if (rst) begin
      restart_hash();
      want_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{digest_word, word_index, last_word};
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: digest word %08h index %0d last %0b arrived with none expected",
                     $realtime, got.word, got.index, got.last);
        end else begin
          want = want_q.pop_front();
          if (got.word !== want.word || got.index !== want.index || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected word %08h index %0d last %0b, got word %08h index %0d last %0b",
                       $realtime, want.word, want.index, want.last,
                       got.word, got.index, got.last);
          end
        end
      end
      if (in_valid && !in_stall) absorb_request(msg_byte, byte_present, is_last);
    end
    fail_count    <= mismatches;
    pending_words <= want_q.size();
  end

endmodule

/* tb/sha256_stream_hasher_unit_test.sv */
// Top of the SHA-256 stream hasher testbench: clock, reset, message requests and
// output stalls, with the verdict. Depends on sha256_stream_hasher_unit and its checker.
module sha256_stream_hasher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUEST_TARGET = 330;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 250;
  localparam int BOUNDARY_LENS [4] = '{55, 56, 63, 64};

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  msg_byte;
  logic        byte_present;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int fail_count;
  int pending_words;
  int src_idle;
  int sink_idle;
  int hold_seq;
  int requests_sent;
  int quiet_cycles;

  sha256_stream_hasher_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .msg_byte     (msg_byte),
    .byte_present (byte_present),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  sha256_stream_hasher_unit_checker u_digest_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .msg_byte      (msg_byte),
    .byte_present  (byte_present),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .last_word     (last_word),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_request(input bit [7:0] b, input bit present, input bit ends);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    msg_byte     <= b;
    byte_present <= present;
    is_last      <= ends;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic send_message(input int unsigned n);
    bit          tail;
    int unsigned body;
    tail = (n > 0) && ($urandom_range(1) == 1);
    body = n - tail;
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(99) < 8) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, 1'b0);
    end
    send_request(8'($urandom), tail, 1'b1);
  endtask

  // The receiver idles at random; a new hold sequence number starts one long hold-off.
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < sink_idle);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    bit          held;
    int unsigned pick;
    int unsigned mlen;
    held          = 1'b0;
    requests_sent = 0;
    quiet_cycles  = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    msg_byte     <= 8'h00;
    byte_present <= 1'b0;
    is_last      <= 1'b0;
    src_idle     <= 21;
    sink_idle    <= 49;
    hold_seq     <= 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'ha5, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b1);

    while (requests_sent < REQUEST_TARGET || !held) begin
      if (requests_sent >= 2 * REQUEST_TARGET / 3) begin
        src_idle  <= 0;
        sink_idle <= 0;
        if (!held) begin
          // Short messages behind a long output hold-off back the block up to its input.
          held = 1'b1;
          hold_seq <= hold_seq + 1;
          send_message(2);
          send_message(5);
        end
      end else if (requests_sent >= REQUEST_TARGET / 3) begin
        src_idle  <= 49;
        sink_idle <= 21;
      end
      pick = $urandom_range(9);
      case (pick)
        5, 6:    mlen = $urandom_range(50, 70);
        7:       mlen = BOUNDARY_LENS[$urandom_range(3)];
        8:       mlen = $urandom_range(120, 130);
        9:       mlen = $urandom_range(0, 3);
        default: mlen = $urandom_range(0, 12);
      endcase
      if (requests_sent + int'(mlen) > REQUEST_TARGET) begin
        if (requests_sent < REQUEST_TARGET) begin
          mlen = unsigned'(REQUEST_TARGET - requests_sent);
        end else begin
          mlen = 0;
        end
      end
      send_message(mlen);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
